FILE: rtl/sha224_pkg.sv
// Package for the SHA-224 hash core: round constants, initial chain values,
// round and schedule functions. No dependencies.
package sha224_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_e;

  typedef logic [31:0] word_t;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned DigestWords = 7;

  localparam word_t InitChain [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

FILE: rtl/sha224_if.sv
// Valid/ready stream interfaces for the SHA-224 core.
// Depends on nothing.
interface sha224_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha224_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

FILE: rtl/sha224_round.sv
// One SHA-256 round plus one message schedule step, shared over all 64 rounds.
// Depends on sha224_pkg.
module sha224_round (
  input  sha224_pkg::word_t       wv_i [8],
  input  sha224_pkg::word_t       sched_i [16],
  input  logic [5:0]              round_i,
  output sha224_pkg::word_t       wv_o [8],
  output sha224_pkg::word_t       sched_new_o
);
  import sha224_pkg::*;

  word_t t1, t2, ch, maj;

  always_comb begin
    ch  = (wv_i[4] & wv_i[5]) ^ (~wv_i[4] & wv_i[6]);
    maj = (wv_i[0] & wv_i[1]) ^ (wv_i[0] & wv_i[2]) ^ (wv_i[1] & wv_i[2]);
    t1  = wv_i[7] + bsig1(wv_i[4]) + ch + RoundK[round_i] + sched_i[0];
    t2  = bsig0(wv_i[0]) + maj;
    wv_o[7] = wv_i[6];
    wv_o[6] = wv_i[5];
    wv_o[5] = wv_i[4];
    wv_o[4] = wv_i[3] + t1;
    wv_o[3] = wv_i[2];
    wv_o[2] = wv_i[1];
    wv_o[1] = wv_i[0];
    wv_o[0] = t1 + t2;
    // next schedule word, from a window of the last sixteen
    sched_new_o = sig1(sched_i[14]) + sched_i[9] + sig0(sched_i[1]) + sched_i[0];
  end

endmodule

FILE: rtl/sha224_hash_core.sv
// SHA-224 streaming hash core top level: buffer, padding sequencer, round loop.
// Depends on sha224_pkg, sha224_if and sha224_round.
//
//   channel | dir | beat carries
//   in_s    | in  | message_word, valid_bytes, last_word
//   out_m   | out | digest_word, digest_index, digest_last
//
// A non-last beat that fills no block is written into the buffer. A beat that
// completes a block starts the rounds on the single shared round unit, then a
// fold into the chain. A last beat adds padding words and one or two blocks,
// then seven output beats. Ready is low while rounds, padding or the digest
// are in progress; output stalls simply hold the current digest word.
// Reset loads the SHA-224 initial chain and clears the counters.
module sha224_hash_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha224_in_if.sink     in_s,
  sha224_out_if.source  out_m
);
  import sha224_pkg::*;

  state_e      state_q, state_d;
  word_t       chain_q [8];
  word_t       wv_q [8];
  word_t       sched_q [16];
  word_t       wv_nx [8];
  word_t       sched_new;
  logic [3:0]  pos_q;
  logic [5:0]  round_q;
  logic [63:0] bits_q;
  logic [1:0]  pad_q;      // 0: zero fill, length high at word 14; 1: length low; 3: done
  logic        pad_mode_q; // padding active (return to PAD after compress)
  logic [2:0]  oidx_q;

  sha224_round u_round (
    .wv_i       (wv_q),
    .sched_i    (sched_q),
    .round_i    (round_q),
    .wv_o       (wv_nx),
    .sched_new_o(sched_new)
  );

  logic  acc;
  logic  put;
  word_t put_w;
  word_t keep, first_w;
  logic [2:0] nb;

  assign acc = in_s.valid && in_s.ready;
  assign nb  = (in_s.valid_bytes > 3'd4) ? 3'd4 : in_s.valid_bytes;

  always_comb begin
    keep = (nb == 3'd0) ? '0 : (32'hffffffff << (6'd32 - {nb, 3'b000}));
    first_w = (in_s.message_word & keep) | (32'h80 << (5'd24 - {nb[1:0], 3'b000}));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc && pos_q == 4'(BlockWords - 1)) state_d = ST_COMP;
               else if (acc && in_s.last_word) state_d = ST_PAD;
      ST_PAD:  if (pos_q == 4'(BlockWords - 1)) state_d = ST_COMP;
      ST_COMP: if (round_q == 6'(NumRounds - 1)) state_d = ST_FOLD;
      ST_FOLD: if (pad_mode_q) state_d = (pad_q == 2'd3) ? ST_OUT : ST_PAD;
               else state_d = ST_IDLE;
      ST_OUT:  if (out_m.ready && oidx_q == 3'(DigestWords - 1)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_s.ready         = (state_q == ST_IDLE);
    out_m.valid        = (state_q == ST_OUT);
    out_m.digest_word  = chain_q[oidx_q];
    out_m.digest_index = oidx_q;
    out_m.digest_last  = (oidx_q == 3'(DigestWords - 1));
  end

  // word written into the block this cycle, in IDLE or PAD
  always_comb begin
    put = 1'b0;
    put_w = '0;
    unique case (state_q)
      ST_IDLE: begin
        put = acc && (!in_s.last_word || nb == 3'd4);
        put_w = in_s.message_word;
        if (acc && in_s.last_word && nb != 3'd4) begin
          put = 1'b1;
          put_w = first_w;
        end
      end
      ST_PAD: begin
        put = 1'b1;
        if (pad_q == 2'd0 && pos_q == 4'd14) put_w = bits_q[63:32];
        else if (pad_q == 2'd1) put_w = bits_q[31:0];
        else put_w = '0;
      end
      default: ;
    endcase
  end

  // a full-word last beat needs 0x80 as the first padding word
  logic mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pos_q      <= '0;
      round_q    <= '0;
      bits_q     <= '0;
      pad_q      <= '0;
      pad_mode_q <= 1'b0;
      oidx_q     <= '0;
      mark_q     <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= InitChain[i];
        wv_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;
      if (acc) begin
        bits_q <= bits_q + (in_s.last_word ? 64'({nb, 3'b000}) : 64'd32);
        if (in_s.last_word) begin
          pad_mode_q <= 1'b1;
          pad_q      <= '0;
          mark_q     <= (nb == 3'd4);
        end
      end
      if (put || (state_q == ST_PAD)) begin
        pos_q <= pos_q + 4'd1;
        if (state_q == ST_PAD) begin
          if (mark_q) mark_q <= 1'b0;
          else if (pad_q == 2'd0 && pos_q == 4'd14) pad_q <= 2'd1;
          else if (pad_q == 2'd1) pad_q <= 2'd3;
        end
      end
      if (state_q == ST_COMP || (state_q != ST_COMP && state_d == ST_COMP)) begin
        if (state_q != ST_COMP) begin
          round_q <= '0;
          for (int i = 0; i < 8; i++) wv_q[i] <= chain_q[i];
        end else begin
          round_q <= round_q + 6'd1;
          for (int i = 0; i < 8; i++) wv_q[i] <= wv_nx[i];
        end
      end
      if (state_q == ST_FOLD) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wv_q[i];
      end
      if (state_q == ST_OUT && out_m.ready) begin
        if (oidx_q == 3'(DigestWords - 1)) begin
          // last digest beat: rearm for the next message
          oidx_q     <= '0;
          bits_q     <= '0;
          pad_mode_q <= 1'b0;
          pad_q      <= '0;
          pos_q      <= '0;
          for (int i = 0; i < 8; i++) chain_q[i] <= InitChain[i];
        end else begin
          oidx_q <= oidx_q + 3'd1;
        end
      end
    end
  end

  // block buffer used as a shift window: words enter at the top; rounds shift it
  word_t pad_w;
  assign pad_w = mark_q ? 32'h80000000 : put_w;

  always_ff @(posedge clk_i) begin
    if (put || state_q == ST_PAD) begin
      for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i+1];
      sched_q[15] <= (state_q == ST_PAD) ? pad_w : put_w;
    end else if (state_q == ST_COMP) begin
      for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i+1];
      sched_q[15] <= sched_new;
    end
  end

`ifndef SYNTHESIS
  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP) |-> !in_s.ready) else $error("ready during rounds");
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && round_q == 6'd63) |=> (state_q == ST_FOLD))
    else $error("round count");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_m.valid && !out_m.ready) |=> $stable(oidx_q)) else $error("index moved");
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_s.ready && out_m.valid)) else $error("both sides active");
`endif

endmodule

FILE: dv/sha224_tb_if.sv
// Testbench package for the SHA-224 core: the digest scoreboard class.
// Depends on sha224_pkg.
package sha224_tb_pkg;
  import sha224_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  class sha224_digest_board;
    logic [31:0]  chain [8];
    logic [31:0]  blk [16];
    int unsigned  pos;
    logic [63:0]  nbits;
    digest_beat_t pending [$];
    int unsigned  errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = InitChain[i];
      pos = 0;
      nbits = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 64; t++)
        w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
               (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void push_word(logic [31:0] w);
      blk[pos] = w;
      pos = (pos + 1) % 16;
      if (pos == 0) compress();
    endfunction

    // Note one accepted message beat; a last beat pads and queues the digest.
    function void note_message(logic [31:0] w, logic [2:0] nb_in, logic lst);
      int unsigned nb;
      logic [31:0] keep;
      digest_beat_t d;
      if (!lst) begin
        nbits += 32;
        push_word(w);
        return;
      end
      nb = (nb_in > 4) ? 4 : nb_in;
      nbits += 8 * nb;
      if (nb == 4) begin
        push_word(w);
        push_word(32'h8000_0000);
      end else begin
        keep = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nb));
        push_word((w & keep) | (32'h80 << (24 - 8 * nb)));
      end
      while (pos != 14) push_word(32'h0);
      push_word(nbits[63:32]);
      push_word(nbits[31:0]);
      for (int k = 0; k < 7; k++) begin
        d.word = chain[k];
        d.index = 3'(k);
        d.last = (k == 6);
        pending.push_back(d);
      end
      restart();
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // Check one accepted digest beat against the oldest expectation.
    task check_digest(digest_beat_t got);
      digest_beat_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected digest beat %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.word !== want.word)
        report($sformatf("idx %0d word %h want %h", want.index, got.word, want.word));
      if (got.index !== want.index)
        report($sformatf("index %0d want %0d", got.index, want.index));
      if (got.last !== want.last)
        report($sformatf("last %b want %b at idx %0d", got.last, want.last, want.index));
    endtask
  endclass
endpackage

FILE: dv/sha224_hash_core_tb.sv
// Testbench for sha224_hash_core: streams directed and random messages,
// predicts each digest with a scoreboard class and checks every output beat.
// Depends on sha224_pkg, sha224_if, sha224_tb_pkg and the RTL.
module sha224_hash_core_tb;
  import sha224_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm = 1'b0;      // drop idling near the end of the run
  sha224_digest_board board;

  sha224_in_if  in_if ();
  sha224_out_if out_if ();

  sha224_hash_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_s  (in_if),
    .out_m (out_if)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.message_word = '0;
    in_if.valid_bytes = '0;
    in_if.last_word = 1'b0;
    out_if.ready = 1'b0;
  end

  // Send one beat, after a random idle gap unless calm: hold it until the block
  // takes it, and leave valid high for the next beat.
  task automatic send_beat(logic [31:0] w, logic [2:0] nb, logic lst);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.message_word <= w;
    in_if.valid_bytes <= nb;
    in_if.last_word <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_message(w, nb, lst);
  endtask

  task automatic idle_input();
    in_if.valid <= 1'b0;
  endtask

  // Send a message of nwords full words plus a last word with tail bytes.
  task automatic send_message(int nwords, logic [2:0] tail, bit rnd);
    for (int i = 0; i < nwords; i++)
      send_beat(rnd ? $urandom : 32'h6162_6300 + i, 3'($urandom_range(0, 7)), 1'b0);
    send_beat(rnd ? $urandom : 32'h6162_6380, tail, 1'b1);
  endtask

  // Pause until every queued digest beat has come back.
  task automatic drain();
    idle_input();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Output side: random stall bursts, checks on every accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_digest({out_if.digest_word, out_if.digest_index, out_if.digest_last});
  end

  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (!calm) begin
        stall = $urandom_range(1, 18);
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int items;
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, each tail size, full-word ones, oversize counts,
    // the one-word-short-of-length case that forces a second pad block.
    send_beat(32'h0, 3'd0, 1'b1);
    send_beat(32'h6162_63ff, 3'd3, 1'b1);          // "abc", junk below
    send_beat(32'hffff_ffff, 3'd1, 1'b1);
    send_beat(32'hffff_ffff, 3'd2, 1'b1);
    send_beat(32'hffff_ffff, 3'd4, 1'b1);
    send_beat(32'h0000_0000, 3'd7, 1'b1);          // saturates to four
    send_beat(32'haaaa_5555, 3'd5, 1'b1);
    send_beat(32'h5555_aaaa, 3'd6, 1'b1);
    send_message(13, 3'd4, 1'b0);                  // pad spills to second block
    drain();                                       // sender waits for all digests

    // count the 22 directed beats toward the total
    items = 22;
    while (items < 230) begin
      int n;
      if (items > 190) calm = 1'b1;
      case ($urandom_range(0, 3))
        0: n = $urandom_range(0, 3);
        1: n = $urandom_range(12, 16);
        2: n = $urandom_range(0, 20);
        default: n = $urandom_range(28, 34);
      endcase
      send_message(n, 3'($urandom_range(0, 7)), 1'b1);
      items += n + 1;
    end
    idle_input();

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
